// ===== hw/rtl/kdqe_pkg.sv =====
// Shared types, codes and the quadrature step table for the key debounce and
// quadrature event block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kdqe_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned SpdW   = 3;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_RESYNC = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SWITCH = 3'd1,
    EV_CW     = 3'd2,
    EV_CCW    = 3'd3,
    EV_KEY1   = 3'd4,
    EV_KEY2   = 3'd5,
    EV_KEY3   = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_KEY_TICKS    = 2'd0,
    REG_SWITCH_TICKS = 2'd1,
    REG_STEPS        = 2'd2
  } reg_index_t;

  // Pending flag positions.
  localparam int unsigned FlagSwitch = 0;
  localparam int unsigned FlagKey1   = 1;
  localparam int unsigned FlagKey2   = 2;
  localparam int unsigned FlagKey3   = 3;

  localparam logic [CountW-1:0] KeyTicksReset    = 8'd5;
  localparam logic [CountW-1:0] SwitchTicksReset = 8'd2;
  localparam logic [SpdW-1:0]   StepsReset       = 3'd2;

  typedef struct packed {
    logic tick;
    logic resync;
    logic clr_acc;
    logic clr_dir;
  } enc_ctrl_t;

  localparam logic signed [1:0] StepZ = 2'sb00;
  localparam logic signed [1:0] StepP = 2'sb01;
  localparam logic signed [1:0] StepN = 2'sb11;

  localparam logic signed [1:0] QuadStep [16] = '{
    StepZ, StepN, StepP, StepZ,
    StepP, StepZ, StepZ, StepN,
    StepN, StepZ, StepZ, StepP,
    StepZ, StepP, StepN, StepZ
  };

  function automatic logic signed [1:0] quad_step(input logic [1:0] prev,
                                                  input logic [1:0] cur);
    return QuadStep[{prev, cur}];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/key_debounce_quadrature_events.sv =====
// A fetch accepted on s_axis passes the input register, then the output register.
// Throughput: one beat per cycle; the input register refills while a result
// waits in the output register, and only a fetch waits for a free output slot.
// Reset clears all counters, flags and encoder state and loads the register
// defaults (key ticks 5, switch ticks 2, steps per detent 2).
// Depends on kdqe_pkg, kdqe_debounce and kdqe_encoder.
`timescale 1ns / 1ps
`default_nettype none

module key_debounce_quadrature_events import kdqe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  // tdata: key1_level, key2_level, key3_level, switch_level, phase_a, phase_b, zeros.
  input  wire logic [7:0] s_axis_tdata,
  // tuser: cmd.
  input  wire logic [1:0] s_axis_tuser,
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  // tdata: event_code, zeros.
  output logic [7:0]      m_axis_tdata,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic              in_valid;
  cmd_t              in_cmd;
  logic [5:0]        in_pins;
  logic              out_valid;
  event_t            out_code;
  event_t            code;
  logic [CountW-1:0] key_ticks;
  logic [CountW-1:0] switch_ticks;
  logic [SpdW-1:0]   steps;
  logic [3:0]        pending;
  logic [3:0]        pending_next;
  logic [3:0]        set_mask;
  logic [3:0]        clr_mask;
  logic              out_free;
  logic              process;
  logic              tick;
  logic              fetch;
  enc_ctrl_t         enc_ctrl;
  dir_t              direction;

  assign out_free      = !out_valid || m_axis_tready;
  assign process       = in_valid && ((in_cmd != CMD_FETCH) || out_free);
  assign s_axis_tready = !in_valid || process;
  assign tick          = process && (in_cmd == CMD_TICK);
  assign fetch         = process && (in_cmd == CMD_FETCH);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= cmd_t'(s_axis_tuser);
      in_pins <= s_axis_tdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_ticks    <= KeyTicksReset;
      switch_ticks <= SwitchTicksReset;
      steps        <= StepsReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_TICKS:    key_ticks    <= cfg_data;
        REG_SWITCH_TICKS: switch_ticks <= cfg_data;
        REG_STEPS:        steps        <= cfg_data[SpdW-1:0];
        default:          ;
      endcase
    end
  end

  kdqe_debounce u_key1 (
    .clk(clk), .rst(rst), .tick(tick), .pressed(in_pins[0]),
    .limit(key_ticks), .press(set_mask[FlagKey1])
  );
  kdqe_debounce u_key2 (
    .clk(clk), .rst(rst), .tick(tick), .pressed(in_pins[1]),
    .limit(key_ticks), .press(set_mask[FlagKey2])
  );
  kdqe_debounce u_key3 (
    .clk(clk), .rst(rst), .tick(tick), .pressed(in_pins[2]),
    .limit(key_ticks), .press(set_mask[FlagKey3])
  );
  kdqe_debounce u_switch (
    .clk(clk), .rst(rst), .tick(tick), .pressed(!in_pins[3]),
    .limit(switch_ticks), .press(set_mask[FlagSwitch])
  );

  kdqe_encoder u_encoder (
    .clk(clk), .rst(rst), .ctrl(enc_ctrl), .phase({in_pins[4], in_pins[5]}),
    .steps_per_detent(steps), .direction(direction)
  );

  always_comb begin
    code             = EV_NONE;
    clr_mask         = '0;
    enc_ctrl.tick    = tick;
    enc_ctrl.resync  = process && (in_cmd == CMD_RESYNC);
    enc_ctrl.clr_acc = 1'b0;
    enc_ctrl.clr_dir = 1'b0;
    priority if (pending[FlagSwitch]) begin
      code                 = EV_SWITCH;
      clr_mask[FlagSwitch] = 1'b1;
      enc_ctrl.clr_acc     = fetch;
      enc_ctrl.clr_dir     = fetch;
    end else if (direction != DIR_NONE) begin
      code             = (direction == DIR_CW) ? EV_CW : EV_CCW;
      enc_ctrl.clr_dir = fetch;
    end else if (pending[FlagKey1]) begin
      code               = EV_KEY1;
      clr_mask[FlagKey1] = 1'b1;
    end else if (pending[FlagKey2]) begin
      code               = EV_KEY2;
      clr_mask[FlagKey2] = 1'b1;
    end else if (pending[FlagKey3]) begin
      code               = EV_KEY3;
      clr_mask[FlagKey3] = 1'b1;
    end else begin
      code = EV_NONE;
    end
    pending_next = pending;
    if (fetch) begin
      pending_next = pending & ~clr_mask;
    end else if (tick) begin
      pending_next = pending | set_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      pending <= pending_next;
      if (out_free) begin
        out_valid <= fetch;
      end
    end
    if (fetch) begin
      out_code <= code;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kdqe_debounce.sv =====
// Saturating debounce counter for one pin with a one-cycle press pulse.
// Depends on kdqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdqe_debounce import kdqe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              tick,
  input  wire logic              pressed,
  input  wire logic [CountW-1:0] limit,
  output logic                   press
);

  logic [CountW-1:0] count;
  logic [CountW-1:0] count_inc;
  logic              below;

  assign count_inc = count + CountW'(1);
  assign below     = count < limit;
  assign press     = tick && pressed && below && (count_inc == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (tick) begin
      if (!pressed) begin
        count <= '0;
      end else if (below) begin
        count <= count_inc;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kdqe_encoder.sv =====
// Quadrature decoder: phase history, signed step accumulator and direction latch.
// Depends on kdqe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kdqe_encoder import kdqe_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire enc_ctrl_t       ctrl,
  input  wire logic [1:0]      phase,
  input  wire logic [SpdW-1:0] steps_per_detent,
  output dir_t                 direction
);

  logic [1:0]        previous_phase;
  logic signed [3:0] acc;
  logic signed [3:0] acc_next;
  dir_t              direction_next;
  logic [SpdW-1:0]   spd;
  logic signed [4:0] spd_s;
  logic signed [4:0] sum;
  logic signed [4:0] sum_adj;
  logic signed [1:0] step;

  always_comb begin
    spd            = (steps_per_detent == '0) ? SpdW'(1) : steps_per_detent;
    spd_s          = $signed(5'(spd));
    step           = quad_step(previous_phase, phase);
    sum            = 5'(acc) + 5'(step);
    sum_adj        = sum;
    direction_next = direction;
    if (sum >= spd_s) begin
      direction_next = DIR_CW;
      sum_adj        = sum - spd_s;
    end else if (sum <= -spd_s) begin
      direction_next = DIR_CCW;
      sum_adj        = sum + spd_s;
    end
    acc_next = sum_adj[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_phase <= '0;
      acc            <= '0;
      direction      <= DIR_NONE;
    end else begin
      if (ctrl.tick && (phase != previous_phase)) begin
        previous_phase <= phase;
        acc            <= acc_next;
        direction      <= direction_next;
      end
      if (ctrl.resync) begin
        previous_phase <= phase;
        acc            <= '0;
      end
      if (ctrl.clr_acc) begin
        acc <= '0;
      end
      if (ctrl.clr_dir) begin
        direction <= DIR_NONE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kdqe_checker.sv =====
// Port-level checks for key_debounce_quadrature_events, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module kdqe_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Output beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("Output beat changed while stalled.");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'b0) && (m_axis_tdata[2:0] != 3'd7))
    else $error("Event code out of range.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Output beat present after reset.");

endmodule

bind key_debounce_quadrature_events kdqe_checker u_kdqe_checker (.*);

`default_nettype wire
